// ===== sv/utl1_pkg.sv =====
// Shared types, register indexes and decode tables for the UTF to Latin-1 converter.
package utl1_pkg;

    // input encoding register codes
    typedef enum logic [1:0] {
        ENC_UTF8  = 2'd0,
        ENC_UTF16 = 2'd1,
        ENC_UTF32 = 2'd2
    } t_enc;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENCODING      = 2'd0,
        CFG_LIMIT_ENABLED = 2'd1,
        CFG_CHAR_LIMIT    = 2'd2
    } t_cfg_idx;

    localparam logic [7:0]  REPLACEMENT_CHAR = 8'h3F;   // '?'
    localparam logic [7:0]  LATIN1_MAX       = 8'hFF;
    localparam logic [15:0] CHAR_COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] HI_SURR_FIRST    = 16'hD800;
    localparam logic [15:0] HI_SURR_LAST     = 16'hDBFF;

    // Number of trailing bytes announced by a UTF-8 lead byte.
    function automatic logic [2:0] utf8_trail_count(input logic [7:0] b);
        logic [2:0] n;
        begin
            priority if (b >= 8'hFC) n = 3'd5;
            else if (b >= 8'hF8) n = 3'd4;
            else if (b >= 8'hF0) n = 3'd3;
            else if (b >= 8'hE0) n = 3'd2;
            else if (b >= 8'hC0) n = 3'd1;
            else n = 3'd0;
            return n;
        end
    endfunction

    // Offset removed from the shifted byte sum for a given trailing count.
    function automatic logic [31:0] utf8_offset(input logic [2:0] len);
        logic [31:0] off;
        begin
            unique case (len)
                3'd1:    off = 32'h0000_3080;
                3'd2:    off = 32'h000E_2080;
                3'd3:    off = 32'h03C8_2080;
                3'd4:    off = 32'hFA08_2080;
                3'd5:    off = 32'h8208_2080;
                default: off = 32'h0000_0000;
            endcase
            return off;
        end
    endfunction

endpackage

// ===== sv/utf_to_latin1_converter.sv =====
// Top level of the UTF-8/16/32 to Latin-1 character converter.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_code_unit[31:0]
//  out     | source    | o_out_valid / i_out_ready  | o_out_char, o_is_last, o_char_count
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index[1:0], i_cfg_data[15:0]
//
// One code unit is taken every cycle while the output does not stall; a decoded character
// passes from its last code unit through the input register, then the result register.
// A single decode pass lies between the two registers.
// Reset clears the decode state, the count, both valid flags and the configuration registers.
// A stalled output holds its word; the input register then fills and o_in_ready drops.
// The configuration port is always ready.
module utf_to_latin1_converter
    import utl1_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_code_unit,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_is_last,
    output logic [15:0] o_char_count,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // compare width wide enough for both the count and the 16-bit limit
    localparam int CmpW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // configuration registers
    t_enc             r_enc;
    logic             r_lim_en;
    logic [15:0]      r_lim;

    // input register
    logic             r_in_vld;
    logic [31:0]      r_unit;

    // decode state
    logic [2:0]       r_trail,   n_trail;
    logic [2:0]       r_seq,     n_seq;
    logic [31:0]      r_acc,     n_acc;
    logic             r_skip,    n_skip;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;

    // result register
    logic             r_out_vld;
    logic [7:0]       r_char,    n_char;
    logic             r_last,    n_last;
    logic [15:0]      r_count,   n_count;

    logic             w_go;
    logic             w_emit;
    logic [31:0]      w_cp;
    logic [7:0]       w_byte;
    logic [2:0]       w_lead_n;
    logic [31:0]      w_sum;
    logic [2:0]       w_trail_dec;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [CmpW-1:0]  w_cnt_ext;
    logic [CmpW-1:0]  w_lim_ext;
    logic [15:0]      w_lim_eff;
    logic             w_cfg_wr;

    // advance the input register into the decode pass when the result slot frees up
    assign w_go        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_go;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    assign o_out_valid  = r_out_vld;
    assign o_out_char   = r_char;
    assign o_is_last    = r_last;
    assign o_char_count = r_count;

    // UTF-8 pieces
    assign w_byte      = r_unit[7:0];
    assign w_lead_n    = utf8_trail_count(w_byte);
    assign w_sum       = r_acc + {24'd0, w_byte};
    assign w_trail_dec = r_trail - 3'd1;

    // limit of zero acts as a limit of one
    assign w_lim_eff = (r_lim == 16'd0) ? 16'd1 : r_lim;
    assign w_cnt_inc = (r_cnt == {COUNT_BITS{1'b1}}) ? r_cnt : r_cnt + COUNT_BITS'(1);
    assign w_cnt_ext = CmpW'(w_cnt_inc);
    assign w_lim_ext = CmpW'(w_lim_eff);

    // decode pass: code point selection, state update, then the character emit
    always_comb begin
        n_trail = r_trail;
        n_seq   = r_seq;
        n_acc   = r_acc;
        n_skip  = r_skip;
        n_cnt   = r_cnt;
        w_emit  = 1'b0;
        w_cp    = 32'd0;
        n_char  = r_char;
        n_last  = r_last;
        n_count = r_count;

        unique case (r_enc)
            ENC_UTF8: begin
                if (r_trail == 3'd0) begin
                    if (w_lead_n == 3'd0) begin
                        w_emit = 1'b1;
                        w_cp   = {24'd0, w_byte};
                    end else begin
                        n_acc   = {18'd0, w_byte, 6'd0};
                        n_trail = w_lead_n;
                        n_seq   = w_lead_n;
                    end
                end else begin
                    n_trail = w_trail_dec;
                    if (w_trail_dec != 3'd0) begin
                        n_acc = w_sum << 6;
                    end else begin
                        w_emit = 1'b1;
                        w_cp   = w_sum - utf8_offset(r_seq);
                        n_acc  = 32'd0;
                        n_seq  = 3'd0;
                    end
                end
            end
            ENC_UTF16: begin
                if (r_skip) begin
                    // drop the unit after a high surrogate
                    n_skip = 1'b0;
                end else begin
                    w_emit = 1'b1;
                    w_cp   = {16'd0, r_unit[15:0]};
                    if (r_unit[15:0] >= HI_SURR_FIRST && r_unit[15:0] <= HI_SURR_LAST) begin
                        n_skip = 1'b1;
                    end
                end
            end
            ENC_UTF32: begin
                w_emit = 1'b1;
                w_cp   = r_unit;
            end
            default: begin
                // unused encoding: drop the unit, keep state
            end
        endcase

        if (w_emit) begin
            n_char = (w_cp > {24'd0, LATIN1_MAX}) ? REPLACEMENT_CHAR : w_cp[7:0];
            if (n_char == 8'd0) begin
                n_last  = 1'b1;
                n_count = (CmpW'(r_cnt) > CmpW'(CHAR_COUNT_MAX)) ? CHAR_COUNT_MAX
                                                                  : 16'(CmpW'(r_cnt));
            end else begin
                n_cnt   = w_cnt_inc;
                n_last  = r_lim_en && (w_cnt_ext >= w_lim_ext);
                n_count = (w_cnt_ext > CmpW'(CHAR_COUNT_MAX)) ? CHAR_COUNT_MAX
                                                               : w_cnt_ext[15:0];
            end
            // end of string: return to the idle decode state
            if (n_last) begin
                n_trail = 3'd0;
                n_seq   = 3'd0;
                n_acc   = 32'd0;
                n_skip  = 1'b0;
                n_cnt   = '0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc    <= ENC_UTF8;
            r_lim_en <= 1'b0;
            r_lim    <= 16'd0;
        end else if (w_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENCODING:      r_enc    <= t_enc'(i_cfg_data[1:0]);
                CFG_LIMIT_ENABLED: r_lim_en <= i_cfg_data[0];
                CFG_CHAR_LIMIT:    r_lim    <= i_cfg_data;
                default: begin
                    // index outside the register list: drop the write
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_unit <= i_code_unit;
        end
    end

    // decode state; an encoding write clears any pending sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trail <= 3'd0;
            r_seq   <= 3'd0;
            r_acc   <= 32'd0;
            r_skip  <= 1'b0;
            r_cnt   <= '0;
        end else if (w_cfg_wr && t_cfg_idx'(i_cfg_index) == CFG_ENCODING) begin
            r_trail <= 3'd0;
            r_seq   <= 3'd0;
            r_acc   <= 32'd0;
            r_skip  <= 1'b0;
        end else if (w_go) begin
            r_trail <= n_trail;
            r_seq   <= n_seq;
            r_acc   <= n_acc;
            r_skip  <= n_skip;
            r_cnt   <= n_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_go) begin
            r_out_vld <= w_emit;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) begin
            r_char  <= n_char;
            r_last  <= n_last;
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/utl1_checker.sv =====
// Port-level checker for the UTF to Latin-1 converter, with its bind statement.
module utl1_checker
    import utl1_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_char,
    input logic        o_is_last,
    input logic [15:0] o_char_count
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_char) && $stable(o_is_last)
             && $stable(o_char_count)))
        else $error("output word changed while stalled");

    // a null always ends the string
    a_null_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_char == 8'd0) |-> o_is_last)
        else $error("null character without end of string");

    // a non-null character is counted
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_char != 8'd0) |-> (o_char_count != 16'd0))
        else $error("converted character with zero count");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // the input side is never left blocked while the output is empty
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid) |=> (o_in_ready || o_out_valid))
        else $error("input blocked with an empty output");

endmodule

bind utf_to_latin1_converter utl1_checker u_utl1_checker (.*);
